// ===== hdl/u8d_pkg.sv =====
// ============================================================================
// u8d_pkg: shared types and constants of the UTF-8 code point decoder
// Holds the byte class patterns, the code point limits and the command beat
// passed from the front end to the result sequencer.
// ============================================================================
package u8d_pkg;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned PARTIAL_W = 15;

  // Byte class masks and tags.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Sequence lengths.
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // Code point limits.
  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
  localparam logic [CP_W-1:0] MIN_CP4 = 21'h010000;
  localparam logic [CP_W-1:0] MIN_CP3 = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP2 = 21'h000080;
  // Bits 15:11 of every surrogate code point U+D800..U+DFFF.
  localparam logic [4:0]      SURR_TAG = 5'b11011;

  // One command: count results, all U+FFFD replacements except the last,
  // which carries cp and rep.
  typedef struct packed {
    logic [2:0]      count;
    logic [CP_W-1:0] cp;
    logic            rep;
  } u8d_cmd_t;

endpackage

// ===== hdl/u8d_front.sv =====
// ============================================================================
// u8d_front: byte classifier and sequence collector
// Tracks the open sequence and turns each accepted byte that causes results
// into one command describing them.
// ============================================================================
module u8d_front import u8d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  output logic       push,
  output u8d_cmd_t   cmd
);

  logic [1:0]           pend_r,    pend_nxt;
  logic [2:0]           seqlen_r,  seqlen_nxt;
  logic [PARTIAL_W-1:0] partial_r, partial_nxt;

  logic            cont;
  logic            ascii;
  logic [2:0]      got;
  logic [2:0]      prefix;
  logic [CP_W-1:0] acc_cp;
  logic [2:0]      lead_len;
  logic [4:0]      lead_val;
  logic            value_ok;

  always_comb begin
    cont   = (data_byte & CONT_MASK) == CONT_TAG;
    ascii  = ~data_byte[7];
    got    = {1'b0, pend_r} + 3'd1;
    prefix = {1'b0, pend_r};
    acc_cp = {partial_r, data_byte[5:0]};

    lead_len = 3'd0;
    lead_val = 5'd0;
    priority if ((data_byte & LEAD2_MASK) == LEAD2_TAG) begin
      lead_len = SEQ_LEN2;
      lead_val = data_byte[4:0];
    end else if ((data_byte & LEAD3_MASK) == LEAD3_TAG) begin
      lead_len = SEQ_LEN3;
      lead_val = {1'b0, data_byte[3:0]};
    end else if ((data_byte & LEAD4_MASK) == LEAD4_TAG) begin
      lead_len = SEQ_LEN4;
      lead_val = {2'b00, data_byte[2:0]};
    end else begin
      lead_len = 3'd0;
    end

    unique case (seqlen_r)
      SEQ_LEN2: value_ok = acc_cp >= MIN_CP2;
      SEQ_LEN3: value_ok = (acc_cp >= MIN_CP3) && (acc_cp[15:11] != SURR_TAG);
      SEQ_LEN4: value_ok = (acc_cp >= MIN_CP4) && (acc_cp <= MAX_CP);
      default:  value_ok = 1'b0;
    endcase

    pend_nxt    = pend_r;
    seqlen_nxt  = seqlen_r;
    partial_nxt = partial_r;
    cmd.count   = 3'd0;
    cmd.cp      = REPL_CP;
    cmd.rep     = 1'b1;

    if ((pend_r != 2'd0) && cont) begin
      if (got >= seqlen_r) begin
        pend_nxt    = 2'd0;
        seqlen_nxt  = 3'd0;
        partial_nxt = '0;
        if (value_ok) begin
          cmd.count = 3'd1;
          cmd.cp    = acc_cp;
          cmd.rep   = 1'b0;
        end else begin
          cmd.count = seqlen_r;
        end
      end else if (stream_end) begin
        pend_nxt    = 2'd0;
        seqlen_nxt  = 3'd0;
        partial_nxt = '0;
        cmd.count   = got;
      end else begin
        pend_nxt    = got[1:0];
        partial_nxt = acc_cp[PARTIAL_W-1:0];
      end
    end else begin
      // Any pending bytes were broken off; the byte is judged afresh on its own.
      pend_nxt    = 2'd0;
      seqlen_nxt  = 3'd0;
      partial_nxt = '0;
      if (ascii) begin
        cmd.count = prefix + 3'd1;
        cmd.cp    = {{(CP_W-8){1'b0}}, data_byte};
        cmd.rep   = 1'b0;
      end else if ((lead_len != 3'd0) && !stream_end) begin
        cmd.count   = prefix;
        pend_nxt    = 2'd1;
        seqlen_nxt  = lead_len;
        partial_nxt = {{(PARTIAL_W-5){1'b0}}, lead_val};
      end else begin
        cmd.count = prefix + 3'd1;
      end
    end

    push = accept && (cmd.count != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 2'd0;
      seqlen_r  <= 3'd0;
      partial_r <= '0;
    end else if (accept) begin
      pend_r    <= pend_nxt;
      seqlen_r  <= seqlen_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

// ===== hdl/u8d_queue.sv =====
// ============================================================================
// u8d_queue: command queue between front end and result sequencer
// A small register FIFO of commands with full and empty flags.
// ============================================================================
module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  u8d_cmd_t push_cmd,
  input  logic     pop,
  output u8d_cmd_t pop_cmd,
  output logic     full,
  output logic     empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8d_cmd_t             slots_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r,  count_nxt;

  always_comb begin
    full    = count_r == CNT_W'(DEPTH);
    empty   = count_r == '0;
    pop_cmd = slots_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/u8d_back.sv =====
// ============================================================================
// u8d_back: result sequencer
// Expands each command into its result beats and drives the output register.
// ============================================================================
module u8d_back import u8d_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  u8d_cmd_t        q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_cp,
  output logic            out_rep,
  output logic            out_last
);

  logic [2:0]      cur_cnt_r, cur_cnt_nxt;
  logic [CP_W-1:0] cur_cp_r;
  logic            cur_rep_r;
  logic            valid_r,   valid_nxt;
  logic [CP_W-1:0] cp_r;
  logic            rep_r;
  logic            last_r;
  logic            slot_free;
  logic            emit;

  always_comb begin
    slot_free = !valid_r || out_ready;
    emit      = slot_free && (cur_cnt_r != 3'd0);
    q_pop     = !q_empty && ((cur_cnt_r == 3'd0) || (emit && (cur_cnt_r == 3'd1)));

    cur_cnt_nxt = cur_cnt_r;
    if (q_pop) begin
      cur_cnt_nxt = q_cmd.count;
    end else if (emit) begin
      cur_cnt_nxt = cur_cnt_r - 3'd1;
    end

    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cnt_r <= 3'd0;
      valid_r   <= 1'b0;
    end else begin
      cur_cnt_r <= cur_cnt_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cp_r  <= q_cmd.cp;
      cur_rep_r <= q_cmd.rep;
    end
    if (emit) begin
      // Only the final beat of a command carries its own value.
      last_r <= cur_cnt_r == 3'd1;
      cp_r   <= (cur_cnt_r == 3'd1) ? cur_cp_r  : REPL_CP;
      rep_r  <= (cur_cnt_r == 3'd1) ? cur_rep_r : 1'b1;
    end
  end

  assign out_valid = valid_r;
  assign out_cp    = cp_r;
  assign out_rep   = rep_r;
  assign out_last  = last_r;

endmodule

// ===== hdl/utf8_codepoint_decoder.sv =====
// ============================================================================
// utf8_codepoint_decoder: streaming UTF-8 to code point decoder
// Input beats carry one byte each, with tlast on the final byte of a stream.
// Output beats carry one code point each; tuser flags a replacement for an
// invalid byte and tlast marks the final result caused by one input byte.
//
// Usage:
//   The front end classifies each accepted byte and collects sequences. For
//   each byte that causes results it writes one command to a queue of
//   QUEUE_DEPTH entries; the sequencer expands a command into one to four
//   output beats. A byte that only extends an open sequence gives no beat.
//   The first result of a byte passes through the queue, the sequencer's
//   command register and the output register on its way to out_tvalid.
//   Throughput: one byte per cycle while bytes cause at most one result each
//   and the receiver keeps up; a byte with several results holds the sequencer
//   until all are sent; the queue absorbs such bursts before in_tready drops.
//   Reset clears the open sequence, the queue and the output valid flag.
//   When the receiver stalls, the output beat holds, the queue fills, and
//   in_tready falls once the queue is full.
// ============================================================================
module utf8_codepoint_decoder import u8d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tuser,  // [0] is_replacement
  output logic        out_tlast   // last_of_run
);

  logic            accept;
  logic            push;
  u8d_cmd_t        push_cmd;
  logic            q_pop;
  u8d_cmd_t        q_cmd;
  logic            q_full;
  logic            q_empty;
  logic [CP_W-1:0] out_cp;

  // A byte is taken whenever the queue has room for its command.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  u8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_tdata),
    .stream_end (in_tlast),
    .push       (push),
    .cmd        (push_cmd)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  u8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cp    (out_cp),
    .out_rep   (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(24-CP_W){1'b0}}, out_cp};

endmodule
